/* hdl/va_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package va_pkg;

	localparam int FRAC_BITS = 16;
	localparam int QW = 32;
	localparam int DW = QW + FRAC_BITS;
	localparam int DCW = $clog2(DW);
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int CW = 68;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_DIV   = 3'd3,
		OP_SCALE = 3'd4,
		OP_DOT   = 3'd5,
		OP_NORM  = 3'd6,
		OP_REFL  = 3'd7
	} op_t;

	typedef struct packed {
		logic use_mul;
		logic use_sf;
		logic use_div;
		logic use_norm;
	} cls_t;

	typedef struct packed {
		op_t                op;
		cls_t               cls;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [15:0] sf;
	} req_t;

	// {clipped flag, value clipped to the signed QW-bit range}
	function automatic logic [QW:0] clip_q(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] hi;
		logic signed [CW-1:0] lo;
		hi = {{(CW-QW+1){1'b0}}, {(QW-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			return {1'b1, hi[QW-1:0]};
		end else if (v < lo) begin
			return {1'b1, lo[QW-1:0]};
		end
		return {1'b0, v[QW-1:0]};
	endfunction

endpackage
`default_nettype wire

/* hdl/va_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module va_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [2:0]           req_type,
	input  wire logic signed [31:0]   a_x,
	input  wire logic signed [31:0]   a_y,
	input  wire logic signed [31:0]   b_x,
	input  wire logic signed [31:0]   b_y,
	input  wire logic signed [15:0]   scale_factor,
	input  wire logic [va_pkg::QAW:0] q_count,
	output logic                      busy,
	output logic                      push,
	output va_pkg::req_t              push_data
);
	import va_pkg::*;

	logic               valid_s1;
	req_t               req_s1;
	logic [QAW+1:0]     occ;
	logic               accept;
	op_t                op;
	cls_t               cls;

	assign occ    = (QAW+2)'(q_count) + (QAW+2)'(valid_s1);
	assign busy   = occ >= (QAW+2)'(QDEPTH);
	assign accept = start && !busy;
	assign op     = op_t'(req_type);

	// sort the request by the units it needs in the back end
	always_comb begin
		cls = '0;
		unique case (op)
			OP_MUL, OP_DOT: cls.use_mul = 1'b1;
			OP_SCALE: begin
				cls.use_mul = 1'b1;
				cls.use_sf  = 1'b1;
			end
			OP_DIV:  cls.use_div = 1'b1;
			OP_NORM: cls.use_norm = 1'b1;
			OP_REFL: begin
				cls.use_mul  = 1'b1;
				cls.use_norm = 1'b1;
			end
			default: cls = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= '{op: op, cls: cls, ax: a_x, ay: a_y, bx: b_x, by: b_y,
				sf: scale_factor};
		end
	end

	assign push      = valid_s1;
	assign push_data = req_s1;
endmodule
`default_nettype wire

/* hdl/va_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module va_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire va_pkg::req_t         push_data,
	input  wire logic                 pop,
	output logic                      q_valid,
	output va_pkg::req_t              q_data,
	output logic [va_pkg::QAW:0]      q_count
);
	import va_pkg::*;

	req_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_pop;

	assign do_pop  = pop && (count_q != '0);
	assign q_valid = count_q != '0;
	assign q_data  = mem_q[rd_ptr_q];
	assign q_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

/* hdl/va_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module va_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  wire va_pkg::req_t        q_data,
	output logic                     pop,
	output logic signed [31:0]       res_x,
	output logic signed [31:0]       res_y,
	output logic                     saturated,
	output logic                     div_zero,
	output logic                     done
);
	import va_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_M1, S_M2, S_FIN, S_R0, S_R1, S_R2, S_R3,
		S_SQ1, S_SQ2, S_SQS, S_SQI, S_DSET, S_DRUN, S_DFIN, S_OUT
	} state_t;

	state_t               state_q;
	req_t                 req_q;
	logic signed [63:0]   p1_q, p2_q;
	logic signed [31:0]   d_q, vx_q, vy_q, rx_q, ry_q;
	logic                 sat_q, dz_q;
	logic [63:0]          rem_q, root_q, bit_q;
	logic [DW-1:0]        num_q, quo_q;
	logic [31:0]          drem_q, dsor_q;
	logic                 neg_q, comp_y_q;
	logic [DCW-1:0]       dcnt_q;

	logic signed [31:0]   mul_a, mul_b, sf_ext;
	logic signed [63:0]   prod;
	logic [QW:0]          fin_x, fin_y, dot_c, tx_c, ty_c, ux_c, uy_c, vx_c, vy_c, q_c;
	logic signed [32:0]   sum_x, sum_y;
	logic signed [64:0]   dot_sum;
	logic signed [33:0]   dbl_x, dbl_y;
	logic signed [32:0]   dif_x, dif_y;
	logic [63:0]          sq_try;
	logic                 sq_ge;
	logic [32:0]          trial, trial_sub;
	logic                 div_ge;
	logic signed [31:0]   dnum;
	logic signed [31:0]   dden;
	logic [31:0]          dnum_abs, dden_abs;
	logic signed [DW:0]   q_signed;

	assign sf_ext = 32'(req_q.sf);

	always_comb begin
		unique case (state_q)
			S_M1: begin
				mul_a = req_q.ax;
				mul_b = req_q.cls.use_sf ? sf_ext : req_q.bx;
			end
			S_M2: begin
				mul_a = req_q.ay;
				mul_b = req_q.cls.use_sf ? sf_ext : req_q.by;
			end
			S_R1: begin
				mul_a = req_q.bx;
				mul_b = d_q;
			end
			S_R2: begin
				mul_a = req_q.by;
				mul_b = d_q;
			end
			S_SQ1: begin
				mul_a = vx_q;
				mul_b = vx_q;
			end
			S_SQ2: begin
				mul_a = vy_q;
				mul_b = vy_q;
			end
			default: begin
				mul_a = req_q.ax;
				mul_b = req_q.bx;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// simple ops finish here: add/sub from the operands, mul, scale and dot from the held products
	always_comb begin
		dot_sum = 65'(p1_q) + 65'(p2_q);
		dot_c   = clip_q(CW'(dot_sum >>> FRAC_BITS));
		sum_x   = '0;
		sum_y   = '0;
		unique case (req_q.op)
			OP_ADD: begin
				sum_x = 33'(req_q.ax) + 33'(req_q.bx);
				sum_y = 33'(req_q.ay) + 33'(req_q.by);
				fin_x = clip_q(CW'(sum_x));
				fin_y = clip_q(CW'(sum_y));
			end
			OP_SUB: begin
				sum_x = 33'(req_q.ax) - 33'(req_q.bx);
				sum_y = 33'(req_q.ay) - 33'(req_q.by);
				fin_x = clip_q(CW'(sum_x));
				fin_y = clip_q(CW'(sum_y));
			end
			OP_MUL: begin
				fin_x = clip_q(CW'(p1_q >>> FRAC_BITS));
				fin_y = clip_q(CW'(p2_q >>> FRAC_BITS));
			end
			OP_SCALE: begin
				fin_x = clip_q(CW'(p1_q));
				fin_y = clip_q(CW'(p2_q));
			end
			OP_DOT: begin
				fin_x = dot_c;
				fin_y = '0;
			end
			default: begin
				fin_x = '0;
				fin_y = '0;
			end
		endcase
	end

	// reflect: v = A - 2 * clip(B * d), each step clipped
	always_comb begin
		tx_c  = clip_q(CW'(p1_q >>> FRAC_BITS));
		ty_c  = clip_q(CW'(p2_q >>> FRAC_BITS));
		dbl_x = 34'($signed(tx_c[QW-1:0])) * 34'sd2;
		dbl_y = 34'($signed(ty_c[QW-1:0])) * 34'sd2;
		ux_c  = clip_q(CW'(dbl_x));
		uy_c  = clip_q(CW'(dbl_y));
		dif_x = 33'(req_q.ax) - 33'($signed(ux_c[QW-1:0]));
		dif_y = 33'(req_q.ay) - 33'($signed(uy_c[QW-1:0]));
		vx_c  = clip_q(CW'(dif_x));
		vy_c  = clip_q(CW'(dif_y));
	end

	assign sq_try = root_q + bit_q;
	assign sq_ge  = rem_q >= sq_try;

	// divider operand select
	always_comb begin
		if (req_q.op == OP_DIV) begin
			dnum = comp_y_q ? req_q.ay : req_q.ax;
			dden = comp_y_q ? req_q.by : req_q.bx;
		end else begin
			dnum = comp_y_q ? vy_q : vx_q;
			dden = root_q[31:0];
		end
		dnum_abs = dnum[31] ? 32'(-dnum) : 32'(dnum);
		dden_abs = (req_q.op == OP_DIV && dden[31]) ? 32'(-dden) : 32'(dden);
	end

	assign trial     = {drem_q, num_q[DW-1]};
	assign div_ge    = trial >= {1'b0, dsor_q};
	assign trial_sub = trial - {1'b0, dsor_q};
	assign q_signed  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign q_c       = clip_q(CW'(q_signed));

	assign pop = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_data.cls.use_div) begin
							state_q <= S_DSET;
						end else if (q_data.cls.use_mul) begin
							state_q <= S_M1;
						end else if (q_data.cls.use_norm) begin
							state_q <= S_SQ1;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= req_q.cls.use_norm ? S_R0 : S_FIN;
				S_FIN: state_q <= S_OUT;
				S_R0: state_q <= S_R1;
				S_R1: state_q <= S_R2;
				S_R2: state_q <= S_R3;
				S_R3: state_q <= S_SQ1;
				S_SQ1: state_q <= S_SQ2;
				S_SQ2: state_q <= S_SQS;
				S_SQS: state_q <= S_SQI;
				S_SQI: begin
					if (bit_q[0]) begin
						state_q <= S_DSET;
					end
				end
				S_DSET: begin
					if (dden_abs == '0) begin
						state_q <= comp_y_q ? S_OUT : S_DSET;
					end else begin
						state_q <= S_DRUN;
					end
				end
				S_DRUN: begin
					if (dcnt_q == DCW'(DW - 1)) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN: state_q <= comp_y_q ? S_OUT : S_DSET;
				S_OUT: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q    <= q_data;
				sat_q    <= 1'b0;
				dz_q     <= 1'b0;
				comp_y_q <= 1'b0;
				vx_q     <= q_data.ax;
				vy_q     <= q_data.ay;
			end
			S_M1, S_R1, S_SQ1: p1_q <= prod;
			S_M2, S_R2, S_SQ2: p2_q <= prod;
			S_FIN: begin
				rx_q  <= $signed(fin_x[QW-1:0]);
				ry_q  <= $signed(fin_y[QW-1:0]);
				sat_q <= fin_x[QW] | fin_y[QW];
			end
			S_R0: begin
				d_q   <= $signed(dot_c[QW-1:0]);
				sat_q <= dot_c[QW];
			end
			S_R3: begin
				vx_q  <= $signed(vx_c[QW-1:0]);
				vy_q  <= $signed(vy_c[QW-1:0]);
				sat_q <= sat_q | tx_c[QW] | ty_c[QW] | ux_c[QW] | uy_c[QW]
					| vx_c[QW] | vy_c[QW];
			end
			S_SQS: begin
				rem_q  <= 64'(p1_q) + 64'(p2_q);
				root_q <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
			end
			S_SQI: begin
				if (sq_ge) begin
					rem_q  <= rem_q - sq_try;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DSET: begin
				if (dden_abs == '0) begin
					dz_q <= 1'b1;
					if (comp_y_q) begin
						ry_q <= '0;
					end else begin
						rx_q <= '0;
					end
					comp_y_q <= 1'b1;
				end else begin
					num_q  <= {dnum_abs, {FRAC_BITS{1'b0}}};
					dsor_q <= dden_abs;
					neg_q  <= dnum[31] ^ (req_q.op == OP_DIV && dden[31]);
					drem_q <= '0;
					quo_q  <= '0;
					dcnt_q <= '0;
				end
			end
			S_DRUN: begin
				drem_q <= div_ge ? trial_sub[31:0] : trial[31:0];
				quo_q  <= {quo_q[DW-2:0], div_ge};
				num_q  <= num_q << 1;
				dcnt_q <= dcnt_q + 1'b1;
			end
			S_DFIN: begin
				if (comp_y_q) begin
					ry_q <= $signed(q_c[QW-1:0]);
				end else begin
					rx_q <= $signed(q_c[QW-1:0]);
				end
				sat_q    <= sat_q | q_c[QW];
				comp_y_q <= 1'b1;
			end
			S_OUT: begin
				res_x     <= rx_q;
				res_y     <= ry_q;
				saturated <= sat_q;
				div_zero  <= dz_q;
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

/* hdl/vector2d_alu_top.sv */
// Two-dimensional vector unit on signed Q16.16 operands. Raise start with a request
// while busy is low; the request is taken at that edge and parked in a four-entry
// queue, so several requests can be issued back to back before busy rises. Results
// come out in request order, each on res_x/res_y/saturated/div_zero for exactly one
// cycle with done high; there is no way to hold them off, so capture them on done.
// One shared 32x32 multiplier, a two-bit-a-step square root and a one-bit-a-step
// divider set the service time per request. Divide runs the divider once per
// component; normalize squares both components, takes the square root, then
// divides each component by it; reflect-normalize runs the reflect steps first.
// The back end pulls a request from the queue only when idle, one at a time.
`timescale 1ns / 1ps
`default_nettype none
module vector2d_alu_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         req_type,
	input  wire logic signed [31:0] a_x,
	input  wire logic signed [31:0] a_y,
	input  wire logic signed [31:0] b_x,
	input  wire logic signed [31:0] b_y,
	input  wire logic signed [15:0] scale_factor,
	output logic                    done,
	output logic signed [31:0]      res_x,
	output logic signed [31:0]      res_y,
	output logic                    saturated,
	output logic                    div_zero
);
	import va_pkg::*;

	logic           push, pop, q_valid;
	req_t           push_data, q_data;
	logic [QAW:0]   q_count;

	va_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .req_type(req_type),
		.a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y), .scale_factor(scale_factor),
		.q_count(q_count), .busy(busy), .push(push), .push_data(push_data)
	);

	va_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .pop(pop),
		.q_valid(q_valid), .q_data(q_data), .q_count(q_count)
	);

	va_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_data(q_data), .pop(pop),
		.res_x(res_x), .res_y(res_y), .saturated(saturated), .div_zero(div_zero),
		.done(done)
	);
endmodule
`default_nettype wire

/* hdl/va_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module va_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic signed [31:0] res_x,
	input wire logic signed [31:0] res_y,
	input wire logic               div_zero
);
	// results never follow one another back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held two cycles");

	// a zero divisor or length zeroes at least one component
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_zero) |-> (res_x == 32'sd0 || res_y == 32'sd0))
		else $error("div_zero with no zero component");

	// the queue fills only through an accepted request
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose with no request taken");
endmodule

bind vector2d_alu_top va_checker u_va_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.res_x(res_x), .res_y(res_y), .div_zero(div_zero)
);
`default_nettype wire

/* test/vector2d_alu_top_test.sv */
`timescale 1ns / 1ps
module vector2d_alu_top_test;
	import va_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] req_type = OP_ADD;
	logic signed [31:0] a_x = '0;
	logic signed [31:0] a_y = '0;
	logic signed [31:0] b_x = '0;
	logic signed [31:0] b_y = '0;
	logic signed [15:0] scale_factor = '0;
	wire busy;
	wire done;
	wire signed [31:0] res_x;
	wire signed [31:0] res_y;
	wire saturated;
	wire div_zero;

	typedef struct {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic sat;
		logic dz;
	} vec_result_t;

	vec_result_t pending_results[$];
	int mismatches = 0;
	bit failed = 0;

	localparam logic signed [31:0] QMAX = 32'sh7fffffff;
	localparam logic signed [31:0] QMIN = 32'sh80000000;

	vector2d_alu_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
		.scale_factor(scale_factor), .done(done), .res_x(res_x), .res_y(res_y),
		.saturated(saturated), .div_zero(div_zero)
	);

	always #4 clk = ~clk;

	function automatic logic signed [31:0] sat32(input logic signed [127:0] v,
			inout logic sat);
		if (v > 128'sh7fffffff) begin
			sat = 1'b1;
			return QMAX;
		end
		if (v < -128'sh80000000) begin
			sat = 1'b1;
			return QMIN;
		end
		return v[31:0];
	endfunction

	// arithmetic shift gives floor for negative products
	function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
			input logic signed [31:0] b, inout logic sat);
		logic signed [127:0] p;
		p = 128'(a) * 128'(b);
		return sat32(p >>> FRAC_BITS, sat);
	endfunction

	function automatic logic signed [31:0] fx_dot(input logic signed [31:0] ax,
			input logic signed [31:0] ay, input logic signed [31:0] bx,
			input logic signed [31:0] by, inout logic sat);
		logic signed [127:0] p;
		p = 128'(ax) * 128'(bx) + 128'(ay) * 128'(by);
		return sat32(p >>> FRAC_BITS, sat);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// signed division truncates toward zero
	function automatic void unit_vector(input logic signed [31:0] x,
			input logic signed [31:0] y, output logic signed [31:0] ox,
			output logic signed [31:0] oy, inout logic dz);
		logic [63:0] ux;
		logic [63:0] uy;
		logic signed [127:0] len;
		logic signed [127:0] q;
		ux = x < 0 ? 64'(-65'(x)) : 64'(x);
		uy = y < 0 ? 64'(-65'(y)) : 64'(y);
		len = 128'(int_sqrt(ux * ux + uy * uy));
		if (len == 0) begin
			dz = 1'b1;
			ox = 0;
			oy = 0;
		end else begin
			q = (128'(x) <<< FRAC_BITS) / len;
			ox = q[31:0];
			q = (128'(y) <<< FRAC_BITS) / len;
			oy = q[31:0];
		end
	endfunction

	function automatic logic signed [31:0] fx_div(input logic signed [31:0] a,
			input logic signed [31:0] b, inout logic sat, inout logic dz);
		if (b == 0) begin
			dz = 1'b1;
			return 0;
		end
		return sat32((128'(a) <<< FRAC_BITS) / 128'(b), sat);
	endfunction

	function automatic vec_result_t predict_vector_op(input op_t op,
			input logic signed [31:0] ax, input logic signed [31:0] ay,
			input logic signed [31:0] bx, input logic signed [31:0] by,
			input logic signed [15:0] sf);
		vec_result_t r;
		logic signed [31:0] d;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		r = '{0, 0, 1'b0, 1'b0};
		case (op)
			OP_ADD: begin
				r.rx = sat32(128'(ax) + 128'(bx), r.sat);
				r.ry = sat32(128'(ay) + 128'(by), r.sat);
			end
			OP_SUB: begin
				r.rx = sat32(128'(ax) - 128'(bx), r.sat);
				r.ry = sat32(128'(ay) - 128'(by), r.sat);
			end
			OP_MUL: begin
				r.rx = fx_mul(ax, bx, r.sat);
				r.ry = fx_mul(ay, by, r.sat);
			end
			OP_DIV: begin
				r.rx = fx_div(ax, bx, r.sat, r.dz);
				r.ry = fx_div(ay, by, r.sat, r.dz);
			end
			OP_SCALE: begin
				r.rx = sat32(128'(ax) * 128'(sf), r.sat);
				r.ry = sat32(128'(ay) * 128'(sf), r.sat);
			end
			OP_DOT: r.rx = fx_dot(ax, ay, bx, by, r.sat);
			OP_NORM: unit_vector(ax, ay, r.rx, r.ry, r.dz);
			default: begin
				d = fx_dot(ax, ay, bx, by, r.sat);
				tx = fx_mul(bx, d, r.sat);
				ty = fx_mul(by, d, r.sat);
				vx = sat32(128'(ax) - 128'(sat32(128'(tx) * 2, r.sat)), r.sat);
				vy = sat32(128'(ay) - 128'(sat32(128'(ty) * 2, r.sat)), r.sat);
				unit_vector(vx, vy, r.rx, r.ry, r.dz);
			end
		endcase
		return r;
	endfunction

	// start stays high after the last request until the caller drops it
	task automatic send_request(input op_t op, input logic signed [31:0] ax,
			input logic signed [31:0] ay, input logic signed [31:0] bx,
			input logic signed [31:0] by, input logic signed [15:0] sf);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= op;
		a_x <= ax;
		a_y <= ay;
		b_x <= bx;
		b_y <= by;
		scale_factor <= sf;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_results.push_back(predict_vector_op(op, ax, ay, bx, by, sf));
	endtask

	task automatic drop_start();
		start <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		vec_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				failed = 1;
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h %h", res_x, res_y);
			end else begin
				e = pending_results.pop_front();
				if (res_x !== e.rx || res_y !== e.ry || saturated !== e.sat
						|| div_zero !== e.dz) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h %h %b %b got %h %h %b %b",
							e.rx, e.ry, e.sat, e.dz, res_x, res_y, saturated, div_zero);
				end
			end
		end
	end

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3) == 0 ? QMAX : QMIN;
			1: return 32'($urandom_range(0, 65536 * 4)) - 32'sd131072;
			2: return 32'($urandom_range(0, 2)) - 32'sd1;
			3: return $signed({{12{$urandom_range(0, 1) == 1}}, 20'($urandom)});
			default: return $urandom;
		endcase
	endfunction

	task automatic test_extremes();
		send_request(OP_ADD, QMAX, QMIN, 32'sd1, -32'sd1, 16'sd0);
		send_request(OP_SUB, QMIN, QMAX, 32'sd1, -32'sd1, 16'sd0);
		send_request(OP_ADD, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 16'sd0);
		send_request(OP_MUL, QMIN, QMAX, QMIN, QMAX, 16'sd0);
		send_request(OP_MUL, -32'sd1, 32'sd1, 32'sd1, -32'sd1, 16'sd0);
		send_request(OP_DIV, QMAX, 32'sd5, 32'sd1, 32'sd0, 16'sd0);
		send_request(OP_DIV, QMIN, 32'sd0, -32'sd1, 32'sd0, 16'sd0);
		send_request(OP_SCALE, QMAX, QMIN, 0, 0, 16'sh7fff);
		send_request(OP_SCALE, 32'sd3, -32'sd3, 0, 0, 16'sh8000);
		send_request(OP_SCALE, 32'sd3, -32'sd3, 0, 0, -16'sd1);
		send_request(OP_DOT, QMAX, QMAX, QMAX, QMAX, 16'sd0);
		send_request(OP_DOT, QMIN, QMIN, QMAX, QMAX, 16'sd0);
		send_request(OP_DOT, -32'sd1, 32'sd1, 32'sd1, 32'sd1, 16'sd0);
		send_request(OP_NORM, 32'sd0, 32'sd0, 0, 0, 16'sd0);
		send_request(OP_NORM, QMIN, QMIN, 0, 0, 16'sd0);
		send_request(OP_NORM, QMAX, 32'sd0, 0, 0, 16'sd0);
		send_request(OP_NORM, -32'sd1, 32'sd0, 0, 0, 16'sd0);
		send_request(OP_REFL, 32'sd65536, 32'sd0, 32'sd65536, 32'sd0, 16'sd0);
		send_request(OP_REFL, QMAX, QMAX, QMAX, QMIN, 16'sd0);
		send_request(OP_REFL, 32'sd65536, 32'sd65536, 32'sd0, 32'sd65536, 16'sd0);
		send_request(OP_REFL, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'sd0);
		drop_start();
	endtask

	task automatic test_random_requests(input int count);
		repeat (count)
			send_request(op_t'($urandom_range(0, 7)), rand_q(), rand_q(), rand_q(), rand_q(),
				16'($urandom));
		drop_start();
	endtask

	task automatic test_back_to_back(input int count);
		repeat (count) begin
			start <= 1'b1;
			req_type <= 3'($urandom_range(0, 5));
			a_x <= rand_q();
			a_y <= rand_q();
			b_x <= rand_q();
			b_y <= rand_q();
			scale_factor <= 16'($urandom);
			@(posedge clk);
			while (busy) @(posedge clk);
			pending_results.push_back(predict_vector_op(op_t'(req_type), a_x, a_y, b_x, b_y,
				scale_factor));
		end
		start <= 1'b0;
	endtask

	initial begin
		#100_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random_requests(780);
		test_back_to_back(100);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (!failed && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

/* files.f */
hdl/va_pkg.sv
hdl/va_front.sv
hdl/va_queue.sv
hdl/va_back.sv
hdl/vector2d_alu_top.sv
hdl/va_checker.sv
test/vector2d_alu_top_test.sv
